// File: rtl/ahf_pkg.sv
// ----------------------------------------------------------------------------
// ahf_pkg
// Shared types and constants of the 3x3 alpha hole filler.
// ----------------------------------------------------------------------------
package ahf_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int FRAME_WIDTH_RST  = 1024;
  localparam int FRAME_HEIGHT_RST = 1024;
  localparam int ROW_LIMIT        = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int YW        = 10;
  localparam int CH_W      = 8;
  localparam int CELL_W    = 3 * CH_W + 1;
  localparam int NB_CELLS  = 9;
  localparam int CENTER    = 4;
  localparam int SUM_W     = 11;
  localparam int CNT_W     = 4;
  localparam int STEP_W    = 3;

  localparam logic [CH_W-1:0] WHITE = 8'd255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_alpha;
  } ahf_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } ahf_out_t;

  typedef struct packed {
    logic            opaque;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } ahf_cell_t;

  typedef ahf_cell_t [NB_CELLS-1:0] ahf_nbhd_t;

  typedef struct packed {
    logic      start;
    ahf_nbhd_t nb;
  } ahf_fill_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } ahf_fill_res_t;

endpackage

// File: rtl/ahf_ram.sv
// ----------------------------------------------------------------------------
// ahf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ahf_ram import ahf_pkg::*; #(
  parameter int  WIDTH = 2 * CELL_W,
  parameter int  DEPTH = MAX_WIDTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/ahf_fill.sv
// ----------------------------------------------------------------------------
// ahf_fill
// Hole fill of one 3x3 neighborhood: count and sum of opaque neighbor reds,
// then a restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ahf_fill import ahf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  ahf_fill_req_t req,
  output ahf_fill_res_t res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CH_W-1:0]   quo_r, quo_nxt;
  logic              opaque_r, opaque_nxt;
  logic              none_r, none_nxt;
  ahf_cell_t         ctr_r, ctr_nxt;

  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  shifted;
  logic [CH_W-1:0]   fill_val;

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int k = 0; k < NB_CELLS; k++) begin
      if (k != CENTER && req.nb[k].opaque) begin
        sum = sum + SUM_W'(req.nb[k].red);
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign shifted = SUM_W'(div_r) << step_r;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    quo_nxt    = quo_r;
    opaque_nxt = opaque_r;
    none_nxt   = none_r;
    ctr_nxt    = ctr_r;
    if (req.start) begin
      ctr_nxt    = req.nb[CENTER];
      opaque_nxt = req.nb[CENTER].opaque;
      none_nxt   = (cnt == '0);
      rem_nxt    = sum;
      div_nxt    = cnt;
      quo_nxt    = '0;
      step_nxt   = STEP_W'(CH_W - 1);
      if (req.nb[CENTER].opaque || cnt == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= shifted) begin
        rem_nxt         = rem_r - shifted;
        quo_nxt[step_r] = 1'b1;
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    quo_r    <= quo_nxt;
    opaque_r <= opaque_nxt;
    none_r   <= none_nxt;
    ctr_r    <= ctr_nxt;
  end

  assign fill_val  = none_r ? WHITE : quo_r;
  assign res.done  = done_r;
  assign res.red   = opaque_r ? ctr_r.red   : fill_val;
  assign res.green = opaque_r ? ctr_r.green : fill_val;
  assign res.blue  = opaque_r ? ctr_r.blue  : fill_val;

endmodule

// File: rtl/alpha_hole_fill_3x3.sv
// ----------------------------------------------------------------------------
// alpha_hole_fill_3x3
// Streaming 3x3 hole filler for RGBA pixels in raster order, with both
// previous rows held in one line store read and written per pixel.
// ----------------------------------------------------------------------------
// Flow: one item at a time, in_stall high until the FSM is back in S_IDLE. A pixel
//   goes to S_PIX, then S_FILL if it gives a result (8 divider steps for a filled
//   hole); a drain goes to S_FILL from the window, or through S_DR_A, S_DR_L, S_DR_C
//   and S_DR_R (three column reads) from the line store. Output stalls add S_OUT.
// Reset: synchronous; width returns to 1024 (or MAX_WIDTH if smaller), height to 1024,
//   frame position and pending count clear. The line store is not cleared.
// ----------------------------------------------------------------------------
module alpha_hole_fill_3x3 import ahf_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ahf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ahf_out_t             out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int EW    = (WW > CFG_W) ? WW : CFG_W;
  localparam int W_RST = (MAX_WIDTH < FRAME_WIDTH_RST) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int RAM_W = 2 * CELL_W;

  localparam logic [1:0] IDX_FIRST = 2'd0;
  localparam logic [1:0] IDX_MID   = 2'd1;
  localparam logic [1:0] IDX_LAST  = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PIX  = 8'b0000_0010,
    S_DR_A = 8'b0000_0100,
    S_DR_L = 8'b0000_1000,
    S_DR_C = 8'b0001_0000,
    S_DR_R = 8'b0010_0000,
    S_FILL = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  function automatic logic [WW-1:0] eff_width(input logic [CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) return WW'(1);
    if (ve > EW'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(ve);
  endfunction

  function automatic logic [CFG_W-1:0] eff_height(input logic [CFG_W-1:0] v);
    if (v == '0) return CFG_W'(1);
    if (v > CFG_W'(ROW_LIMIT)) return CFG_W'(ROW_LIMIT);
    return v;
  endfunction

  function automatic ahf_cell_t cell_at(input ahf_nbhd_t src, input logic [1:0] row,
      input logic [1:0] col);
    logic [3:0] idx;
    idx = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
    return src[idx];
  endfunction

  function automatic ahf_nbhd_t pick_nbhd(input ahf_nbhd_t src, input logic [1:0] lc,
      input logic [1:0] cc, input logic [1:0] rc, input logic top_clamp);
    ahf_nbhd_t  nb;
    logic [1:0] top;
    top   = top_clamp ? IDX_MID : IDX_FIRST;
    nb[0] = cell_at(src, top, lc);
    nb[1] = cell_at(src, top, cc);
    nb[2] = cell_at(src, top, rc);
    nb[3] = cell_at(src, IDX_MID, lc);
    nb[4] = cell_at(src, IDX_MID, cc);
    nb[5] = cell_at(src, IDX_MID, rc);
    nb[6] = cell_at(src, IDX_LAST, lc);
    nb[7] = cell_at(src, IDX_LAST, cc);
    nb[8] = cell_at(src, IDX_LAST, rc);
    return nb;
  endfunction

  state_t            state_r, state_nxt;
  logic [WW-1:0]     w_eff_r, w_eff_nxt;
  logic [CFG_W-1:0]  h_eff_r, h_eff_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [PW-1:0]     pend_r, pend_nxt;
  ahf_nbhd_t         win_r, win_nxt;
  logic              out_valid_r, out_valid_nxt;

  ahf_cell_t         px_r, px_nxt;
  logic [XW-1:0]     xi_r, xi_nxt;
  logic [YW-1:0]     yi_r, yi_nxt;
  logic [XW-1:0]     col_r, col_nxt;
  logic [RAM_W-1:0]  coll_r, coll_nxt;
  logic [RAM_W-1:0]  colc_r, colc_nxt;
  logic              fe_r, fe_nxt;
  ahf_out_t          out_data_r, out_data_nxt;

  logic              accept;
  logic              is_pixel;
  logic              is_drain;
  logic              pos_out;
  logic [XW-1:0]     x_cur;
  logic [YW-1:0]     y_cur;
  logic [WW-1:0]     x_inc;
  logic [CFG_W-1:0]  y_inc;
  logic [XW-1:0]     x_adv;
  logic [YW-1:0]     y_adv;
  logic              at_origin;
  logic              pix_emit;
  logic [PW-1:0]     pend_base;
  logic [PW-1:0]     w_ext;
  logic [PW-1:0]     col_calc;
  logic              drain_hit;
  logic              drain_win;
  logic              emit_old;
  logic              emit_new;
  logic [1:0]        lc_tail;
  logic [XW-1:0]     lc_addr;
  logic [WW-1:0]     c_inc;
  logic [WW-1:0]     w_dec;
  logic [XW-1:0]     rc_addr;
  logic              out_free;
  logic              out_load;
  ahf_nbhd_t         win_new;
  ahf_nbhd_t         store_nb;

  logic              ram_wr_en;
  logic [RAM_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [XW-1:0]     ram_rd_addr;
  logic [RAM_W-1:0]  ram_rd_data;

  ahf_fill_req_t     fill_req;
  ahf_fill_res_t     fill_res;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_pixel = (in_data.cmd == CMD_PIXEL);
  assign is_drain = (in_data.cmd == CMD_DRAIN);

  assign pos_out   = (WW'(x_r) >= w_eff_r) || (CFG_W'(y_r) >= h_eff_r);
  assign x_cur     = pos_out ? '0 : x_r;
  assign y_cur     = pos_out ? '0 : y_r;
  assign x_inc     = WW'(x_cur) + WW'(1);
  assign y_inc     = CFG_W'(y_cur) + CFG_W'(1);
  assign x_adv     = (x_inc >= w_eff_r) ? '0 : x_inc[XW-1:0];
  assign y_adv     = (x_inc < w_eff_r) ? y_cur :
                     (y_inc >= h_eff_r) ? '0 : y_inc[YW-1:0];
  assign at_origin = (x_cur == '0) && (y_cur == '0);
  assign pix_emit  = ((x_cur == '0) && (y_cur >= YW'(2))) ||
                     ((x_cur != '0) && (y_cur != '0));
  assign pend_base = at_origin ? '0 : pend_r;
  assign w_ext     = PW'(w_eff_r);
  assign col_calc  = w_ext - pend_r;
  assign drain_hit = at_origin && (pend_r != '0);
  assign drain_win = (pend_r > w_ext);

  assign emit_old = (xi_r == '0) && (yi_r >= YW'(2));
  assign emit_new = (xi_r != '0) && (yi_r != '0);
  assign lc_tail  = (w_eff_r == WW'(1)) ? IDX_LAST : IDX_MID;

  assign lc_addr = (col_r == '0) ? '0 : col_r - XW'(1);
  assign c_inc   = WW'(col_r) + WW'(1);
  assign w_dec   = w_eff_r - WW'(1);
  assign rc_addr = (c_inc >= w_eff_r) ? w_dec[XW-1:0] : c_inc[XW-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free && (((state_r == S_FILL) && fill_res.done) || (state_r == S_OUT));

  always_comb begin
    win_new    = win_r;
    win_new[0] = win_r[1];
    win_new[1] = win_r[2];
    win_new[3] = win_r[4];
    win_new[4] = win_r[5];
    win_new[6] = win_r[7];
    win_new[7] = win_r[8];
    win_new[2] = ram_rd_data[RAM_W-1:CELL_W];
    win_new[5] = ram_rd_data[CELL_W-1:0];
    win_new[8] = px_r;
  end

  always_comb begin
    logic [CELL_W-1:0] up_l, up_c, up_r;
    up_l = (h_eff_r == CFG_W'(1)) ? coll_r[CELL_W-1:0] : coll_r[RAM_W-1:CELL_W];
    up_c = (h_eff_r == CFG_W'(1)) ? colc_r[CELL_W-1:0] : colc_r[RAM_W-1:CELL_W];
    up_r = (h_eff_r == CFG_W'(1)) ? ram_rd_data[CELL_W-1:0] : ram_rd_data[RAM_W-1:CELL_W];
    store_nb[0] = up_l;
    store_nb[1] = up_c;
    store_nb[2] = up_r;
    store_nb[3] = coll_r[CELL_W-1:0];
    store_nb[4] = colc_r[CELL_W-1:0];
    store_nb[5] = ram_rd_data[CELL_W-1:0];
    store_nb[6] = coll_r[CELL_W-1:0];
    store_nb[7] = colc_r[CELL_W-1:0];
    store_nb[8] = ram_rd_data[CELL_W-1:0];
  end

  always_comb begin
    fill_req.start = 1'b0;
    fill_req.nb    = pick_nbhd(win_r, lc_tail, IDX_LAST, IDX_LAST, h_eff_r == CFG_W'(2));
    case (state_r)
      S_IDLE: begin
        fill_req.start = accept && is_drain && drain_hit && drain_win;
      end
      S_PIX: begin
        fill_req.start = emit_old || emit_new;
        if (emit_new) begin
          fill_req.nb = pick_nbhd(win_new, (xi_r == XW'(1)) ? IDX_MID : IDX_FIRST,
                                  IDX_MID, IDX_LAST, yi_r == YW'(1));
        end else begin
          fill_req.nb = pick_nbhd(win_r, lc_tail, IDX_LAST, IDX_LAST, yi_r == YW'(2));
        end
      end
      S_DR_R: begin
        fill_req.start = 1'b1;
        fill_req.nb    = store_nb;
      end
      default: begin
        fill_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = x_cur;
    case (state_r)
      S_IDLE: begin
        ram_rd_en = accept && is_pixel;
      end
      S_DR_A: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = lc_addr;
      end
      S_DR_L: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = col_r;
      end
      S_DR_C: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = rc_addr;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  assign ram_wr_en   = (state_r == S_PIX);
  assign ram_wr_data = {ram_rd_data[CELL_W-1:0], px_r};

  always_comb begin
    state_nxt     = state_r;
    w_eff_nxt     = w_eff_r;
    h_eff_nxt     = h_eff_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    pend_nxt      = pend_r;
    win_nxt       = win_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    xi_nxt        = xi_r;
    yi_nxt        = yi_r;
    col_nxt       = col_r;
    coll_nxt      = coll_r;
    colc_nxt      = colc_r;
    fe_nxt        = fe_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_red   = fill_res.red;
      out_data_nxt.out_green = fill_res.green;
      out_data_nxt.out_blue  = fill_res.blue;
      out_data_nxt.frame_end = fe_r;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          xi_nxt = x_cur;
          yi_nxt = y_cur;
          if (is_pixel) begin
            px_nxt.opaque = (in_data.in_alpha != '0);
            px_nxt.red    = in_data.in_red;
            px_nxt.green  = in_data.in_green;
            px_nxt.blue   = in_data.in_blue;
            x_nxt         = x_adv;
            y_nxt         = y_adv;
            pend_nxt      = pix_emit ? pend_base : pend_base + PW'(1);
            fe_nxt        = 1'b0;
            state_nxt     = S_PIX;
          end else begin
            x_nxt = x_cur;
            y_nxt = y_cur;
            if (drain_hit) begin
              pend_nxt  = pend_r - PW'(1);
              fe_nxt    = (pend_r == PW'(1));
              col_nxt   = col_calc[XW-1:0];
              state_nxt = drain_win ? S_FILL : S_DR_A;
            end
          end
        end
      end
      S_PIX: begin
        win_nxt   = win_new;
        state_nxt = (emit_old || emit_new) ? S_FILL : S_IDLE;
      end
      S_DR_A: begin
        state_nxt = S_DR_L;
      end
      S_DR_L: begin
        coll_nxt  = ram_rd_data;
        state_nxt = S_DR_C;
      end
      S_DR_C: begin
        colc_nxt  = ram_rd_data;
        state_nxt = S_DR_R;
      end
      S_DR_R: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (fill_res.done) begin
          state_nxt = out_free ? S_IDLE : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          w_eff_nxt = eff_width(cfg_wdata);
        end
        REG_FRAME_HEIGHT: begin
          h_eff_nxt = eff_height(cfg_wdata);
        end
        default: begin
          w_eff_nxt = w_eff_r;
        end
      endcase
      x_nxt    = '0;
      y_nxt    = '0;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      w_eff_r     <= WW'(W_RST);
      h_eff_r     <= CFG_W'(FRAME_HEIGHT_RST);
      x_r         <= '0;
      y_r         <= '0;
      pend_r      <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_eff_r     <= w_eff_nxt;
      h_eff_r     <= h_eff_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      pend_r      <= pend_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    xi_r       <= xi_nxt;
    yi_r       <= yi_nxt;
    col_r      <= col_nxt;
    coll_r     <= coll_nxt;
    colc_r     <= colc_nxt;
    fe_r       <= fe_nxt;
    out_data_r <= out_data_nxt;
  end

  ahf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (xi_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ahf_fill u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fill_req),
    .res   (fill_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/tb_alpha_hole_fill_3x3.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_hole_fill_3x3
// Self-checking bench for the 3x3 alpha hole filler. A scoreboard class keeps
// its own copy of the row stores, the window and the frame position, predicts
// every result from the accepted items and compares the results field by
// field. Stimulus runs a short directed frame, a few partial frames at the
// largest sizes and then random frames with drains, restarts and random stalls.
// ----------------------------------------------------------------------------
module tb_alpha_hole_fill_3x3;
  import ahf_pkg::*;

  localparam int MAXW          = MAX_WIDTH_DEF;
  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 480;
  localparam int PRINT_LIMIT   = 20;

  class fill_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    ahf_cell_t        older_row [MAXW];
    ahf_cell_t        newer_row [MAXW];
    ahf_cell_t        win [NB_CELLS];
    ahf_cell_t        nb [NB_CELLS];
    int unsigned      col;
    int unsigned      row;
    int unsigned      owed;
    ahf_out_t         expected_q [$];
    int               errors;
    int               checked;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      foreach (older_row[i]) older_row[i] = '0;
      foreach (newer_row[i]) newer_row[i] = '0;
      foreach (win[i]) win[i] = '0;
      col     = 0;
      row     = 0;
      owed    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    static function int unsigned eff_dim(logic [CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      if (idx == REG_FRAME_WIDTH) width_reg = v;
      else height_reg = v;
      col  = 0;
      row  = 0;
      owed = 0;
    endfunction

    function ahf_out_t fill();
      ahf_out_t    r;
      int unsigned sum;
      int unsigned cnt;
      int unsigned avg;
      r   = '0;
      sum = 0;
      cnt = 0;
      if (nb[CENTER].opaque) begin
        r.out_red   = nb[CENTER].red;
        r.out_green = nb[CENTER].green;
        r.out_blue  = nb[CENTER].blue;
        return r;
      end
      for (int i = 0; i < NB_CELLS; i++) begin
        if (i != CENTER && nb[i].opaque) begin
          sum += nb[i].red;
          cnt++;
        end
      end
      avg = (cnt > 0) ? sum / cnt : WHITE;
      r.out_red   = avg[CH_W-1:0];
      r.out_green = avg[CH_W-1:0];
      r.out_blue  = avg[CH_W-1:0];
      return r;
    endfunction

    function ahf_out_t from_window(int lc, int cc, int rc, bit clamp);
      int src [3];
      src[0] = clamp ? 1 : 0;
      src[1] = 1;
      src[2] = 2;
      for (int r = 0; r < 3; r++) begin
        nb[r*3+0] = win[src[r]*3+lc];
        nb[r*3+1] = win[src[r]*3+cc];
        nb[r*3+2] = win[src[r]*3+rc];
      end
      return fill();
    endfunction

    function void note_input(ahf_in_t it);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int unsigned c;
      int          cols [3];
      ahf_cell_t   px;
      ahf_cell_t   top;
      ahf_cell_t   mid;
      ahf_out_t    res;
      bit          hit;
      w   = eff_dim(width_reg, MAXW);
      h   = eff_dim(height_reg, ROW_LIMIT);
      x   = col;
      y   = row;
      hit = 1'b0;
      res = '0;
      if (x >= w || y >= h) begin
        x = 0;
        y = 0;
      end
      if (it.cmd == CMD_PIXEL) begin
        px.opaque = (it.in_alpha != 0);
        px.red    = it.in_red;
        px.green  = it.in_green;
        px.blue   = it.in_blue;
        if (x == 0 && y == 0) owed = 0;
        if (x == 0 && y >= 2) begin
          res = from_window((w == 1) ? 2 : 1, 2, 2, y == 2);
          hit = 1'b1;
        end
        top = older_row[x];
        mid = newer_row[x];
        older_row[x] = mid;
        newer_row[x] = px;
        for (int r = 0; r < 3; r++) begin
          win[r*3+0] = win[r*3+1];
          win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (x >= 1 && y >= 1) begin
          res = from_window((x == 1) ? 1 : 0, 1, 2, y == 1);
          hit = 1'b1;
        end
        if (!hit) owed++;
        x++;
        if (x >= w) begin
          x = 0;
          y++;
          if (y >= h) y = 0;
        end
        col = x;
        row = y;
        if (hit) expected_q.push_back(res);
        return;
      end
      col = x;
      row = y;
      if (!(x == 0 && y == 0) || owed == 0) return;
      if (owed > w) begin
        res = from_window((w == 1) ? 2 : 1, 2, 2, h == 2);
      end else begin
        c = w - owed;
        cols[0] = (c == 0) ? 0 : c - 1;
        cols[1] = c;
        cols[2] = (c + 1 >= w) ? w - 1 : c + 1;
        for (int k = 0; k < 3; k++) begin
          nb[k]   = (h == 1) ? newer_row[cols[k]] : older_row[cols[k]];
          nb[3+k] = newer_row[cols[k]];
          nb[6+k] = newer_row[cols[k]];
        end
        res = fill();
      end
      owed--;
      res.frame_end = (owed == 0);
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(ahf_out_t got);
      ahf_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected (%h)", checked, got));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_red !== want.out_red)
        report($sformatf("result %0d red %0d, want %0d", checked, got.out_red, want.out_red));
      if (got.out_green !== want.out_green)
        report($sformatf("result %0d green %0d, want %0d", checked, got.out_green,
                         want.out_green));
      if (got.out_blue !== want.out_blue)
        report($sformatf("result %0d blue %0d, want %0d", checked, got.out_blue, want.out_blue));
      if (got.frame_end !== want.frame_end)
        report($sformatf("result %0d frame_end %0b, want %0b", checked, got.frame_end,
                         want.frame_end));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  ahf_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  ahf_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  fill_scoreboard sb;
  bit             calm     = 1'b0;
  bit             hold_req = 1'b0;
  int             items_in = 0;
  int             settings = 0;

  alpha_hole_fill_3x3 #(
    .MAX_WIDTH (MAXW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ahf_in_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] a);
    ahf_in_t it;
    it.cmd      = CMD_PIXEL;
    it.in_red   = r;
    it.in_green = g;
    it.in_blue  = b;
    it.in_alpha = a;
    return it;
  endfunction

  function automatic ahf_in_t drain_tick();
    ahf_in_t it;
    it          = ahf_in_t'($urandom());
    it.cmd      = CMD_DRAIN;
    return it;
  endfunction

  function automatic ahf_in_t rand_pixel(int hole_pct);
    logic [7:0] a;
    if ($urandom_range(0, 99) < hole_pct) a = 8'd0;
    else begin
      case ($urandom_range(0, 3))
        0:       a = 8'd1;
        1:       a = 8'd255;
        default: a = 8'($urandom_range(1, 255));
      endcase
    end
    return pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), a);
  endfunction

  task automatic send(ahf_in_t it);
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_in++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic configure(int unsigned w, int unsigned h);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_reg(REG_FRAME_WIDTH, CFG_W'(w));
    set_reg(REG_FRAME_HEIGHT, CFG_W'(h));
  endtask

  task automatic run_frame(int unsigned n_pix, int hole_pct, int drains, bit noisy,
                           int pause_at);
    for (int i = 0; i < n_pix; i++) begin
      if (i == pause_at) wait_results();
      if (noisy && $urandom_range(0, 99) < 6) send(drain_tick());
      send(rand_pixel(hole_pct));
    end
    repeat (drains) send(drain_tick());
  endtask

  // result side: check, then pick next stall
  int hold_left = 0;
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  int idle_cycles = 0;
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned ew;
    int unsigned eh;
    int unsigned owed;
    int          hole;
    int          nframes;
    int          pause_at;
    int          pick;
    int          phase;
    int          start_items;
    bit          cut;

    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(3, 3);
    send(drain_tick());
    send(pixel(8'd255, 8'd255, 8'd255, 8'd255));
    send(pixel(8'd0, 8'd0, 8'd0, 8'd0));
    send(pixel(8'd128, 8'd1, 8'd2, 8'd1));
    send(pixel(8'd0, 8'd255, 8'd0, 8'd0));
    send(pixel(8'd0, 8'd0, 8'd0, 8'd0));
    send(drain_tick());
    send(pixel(8'd200, 8'd100, 8'd50, 8'd128));
    send(pixel(8'd1, 8'd2, 8'd3, 8'd0));
    send(pixel(8'd0, 8'd0, 8'd255, 8'd255));
    send(pixel(8'd255, 8'd0, 8'd0, 8'd0));
    repeat (2) send(drain_tick());
    // restart the frame with results still owed, all holes
    repeat (9) send(pixel(8'd255, 8'd127, 8'd128, 8'd0));
    repeat (5) send(drain_tick());

    configure(2047, 0);
    run_frame(40, 30, 2, 1'b0, -1);
    configure(0, 1024);
    run_frame(40, 40, 2, 1'b0, -1);
    configure(1024, 2047);
    run_frame(30, 50, 0, 1'b0, -1);

    start_items = items_in;
    phase = 0;
    while (items_in - start_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        w = 6;
        h = 5;
      end else begin
        pick = $urandom_range(0, 9);
        w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      end
      configure(w, h);
      calm = (phase == 1);
      ew   = fill_scoreboard::eff_dim(CFG_W'(w), MAXW);
      eh   = fill_scoreboard::eff_dim(CFG_W'(h), ROW_LIMIT);
      owed = (eh == 1) ? ew : ew + 1;
      case ($urandom_range(0, 3))
        0:       hole = 0;
        1:       hole = 30;
        2:       hole = 60;
        default: hole = 100;
      endcase
      nframes = $urandom_range(1, 3);
      cut     = 1'b0;
      for (int f = 0; f < nframes && !cut; f++) begin
        if (phase == 0 && f == 0) hold_req = 1'b1;
        pause_at = (phase == 2 && f == 0) ? int'(ew * eh / 2) : -1;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          run_frame(ew * eh, hole, owed + $urandom_range(0, 2), 1'b1, pause_at);
        end else if (pick < 9) begin
          run_frame(ew * eh, hole, $urandom_range(0, owed - 1), 1'b1, pause_at);
        end else begin
          run_frame($urandom_range(1, ew * eh), hole, 0, 1'b1, pause_at);
          cut = 1'b1;
        end
      end
      calm = 1'b0;
      phase++;
    end

    wait_results();
    repeat (30) @(posedge clk);
    $display("summary: %0d items accepted, %0d results checked, %0d register writes",
             items_in, sb.checked, settings);
    $display("summary: frames from 1x1 up to partial 1024-wide and 1024-tall ones, drains,");
    $display("summary: restarts, a long output hold and random stalls on both sides");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
